@@ src/cht_pkg.sv @@
`timescale 1ns / 1ps
package cht_pkg;

   localparam int ACTION_W   = 3;
   localparam int HANDLE_W   = 6;
   localparam int OBJECT_W   = 32;
   localparam int RIGHTS_W   = 16;
   localparam int STATUS_W   = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam action_type ACT_GRANT    = 3'd0;
   localparam action_type ACT_LOOKUP   = 3'd1;
   localparam action_type ACT_DUP      = 3'd2;
   localparam action_type ACT_RESTRICT = 3'd3;
   localparam action_type ACT_CLOSE    = 3'd4;

   localparam status_type ST_OK    = 3'd0;
   localparam status_type ST_BAD   = 3'd1;
   localparam status_type ST_FULL  = 3'd2;
   localparam status_type ST_NODUP = 3'd3;
   localparam status_type ST_ESCAL = 3'd4;

   localparam logic [RIGHTS_W-1:0] NO_RIGHTS      = 16'h0000;
   localparam logic [RIGHTS_W-1:0] DUP_MASK_RESET = 16'h0001;

   localparam logic [CSR_ADDR_W-1:0] CSR_DUP_MASK_ADDR = 3'd0;

endpackage

@@ src/cht_ram.sv @@
`timescale 1ns / 1ps
module cht_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 49
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

@@ src/capability_handle_table.sv @@
`timescale 1ns / 1ps
// lookup, restrict, close: states FETCH, EXEC, RESP, then the response is registered
// grant: scans SCAN/CHECK from slot 0 over the occupied slots and takes the lowest free one;
// duplicate: FETCH and EXEC, then the grant scan; RESP holds while an older response waits
// refused on arrival (zero object, grant to a full table, bad action or index): straight to RESP
// one request at a time; reset (synchronous) runs a clearing pass over all TABLE_ENTRIES slots
// with req_ready low; duplicate mask resets to 1, response channel empty
module capability_handle_table #(
   parameter int TABLE_ENTRIES = 64,
   parameter int RIGHTS_BITS   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  cht_pkg::action_type                req_action,
   input  logic [cht_pkg::HANDLE_W-1:0]       req_handle_index,
   input  logic [cht_pkg::OBJECT_W-1:0]       req_object_id,
   input  logic [cht_pkg::RIGHTS_W-1:0]       req_rights_mask,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output cht_pkg::status_type                rsp_status,
   output logic [cht_pkg::HANDLE_W-1:0]       rsp_result_handle,
   output logic [cht_pkg::OBJECT_W-1:0]       rsp_result_object,
   output logic [cht_pkg::RIGHTS_W-1:0]       rsp_result_rights,
   output logic                               rsp_rights_ok,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [cht_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [cht_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [cht_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   import cht_pkg::*;

   localparam int RW    = (RIGHTS_BITS < RIGHTS_W) ? RIGHTS_BITS : RIGHTS_W;
   localparam int AW    = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W = ((AW > HANDLE_W) ? AW : HANDLE_W) + 1;
   localparam int EW    = 1 + OBJECT_W + RW;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_CHECK = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [AW-1:0]       scan_ff, scan_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [RIGHTS_W-1:0] dup_ff, dup_in;
   action_type          act_ff, act_in;
   logic [HANDLE_W-1:0] hdl_ff, hdl_in;
   logic [RW-1:0]       need_ff, need_in;
   logic [OBJECT_W-1:0] work_obj_ff, work_obj_in;
   logic [RW-1:0]       work_rights_ff, work_rights_in;
   status_type          res_status_ff, res_status_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic [OBJECT_W-1:0] res_obj_ff, res_obj_in;
   logic [RW-1:0]       res_rights_ff, res_rights_in;
   logic                res_ok_ff, res_ok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [OBJECT_W-1:0] rsp_obj_ff, rsp_obj_in;
   logic [RIGHTS_W-1:0] rsp_rights_ff, rsp_rights_in;
   logic                rsp_ok_ff, rsp_ok_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [EW-1:0]       wr_data;
   logic [AW-1:0]       rd_addr;
   logic [EW-1:0]       rd_data;

   logic                e_valid;
   logic [OBJECT_W-1:0] e_obj;
   logic [RW-1:0]       e_rights;
   logic [IDX_W-1:0]    req_idx_ext;
   logic [IDX_W-1:0]    hdl_ext;
   logic [IDX_W-1:0]    scan_ext;
   logic [AW-1:0]       hdl_addr;
   logic [RW-1:0]       dup_need;
   logic                full;
   logic                last_slot;
   logic                csr_write;
   logic                csr_hit;

   cht_ram #(
      .DEPTH (TABLE_ENTRIES),
      .WIDTH (EW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign e_valid     = rd_data[EW-1];
   assign e_obj       = rd_data[EW-2 -: OBJECT_W];
   assign e_rights    = rd_data[RW-1:0];
   assign req_idx_ext = IDX_W'(req_handle_index);
   assign hdl_ext     = IDX_W'(hdl_ff);
   assign scan_ext    = IDX_W'(scan_ff);
   assign hdl_addr    = hdl_ext[AW-1:0];
   assign dup_need    = dup_ff[RW-1:0];
   assign full        = (cnt_ff == CNT_W'(TABLE_ENTRIES));
   assign last_slot   = (scan_ff == AW'(TABLE_ENTRIES - 1));

   // register port, decoded on the word address
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_hit   = (paddr[CSR_ADDR_W-1:2] == CSR_DUP_MASK_ADDR[CSR_ADDR_W-1:2]);
   assign dup_in    = (csr_write && csr_hit) ? pwdata[RIGHTS_W-1:0] : dup_ff;
   assign prdata    = csr_hit ? CSR_DATA_W'(dup_ff) : '0;

   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      cnt_in         = cnt_ff;
      act_in         = act_ff;
      hdl_in         = hdl_ff;
      need_in        = need_ff;
      work_obj_in    = work_obj_ff;
      work_rights_in = work_rights_ff;
      res_status_in  = res_status_ff;
      res_handle_in  = res_handle_ff;
      res_obj_in     = res_obj_ff;
      res_rights_in  = res_rights_ff;
      res_ok_in      = res_ok_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_obj_in     = rsp_obj_ff;
      rsp_rights_in  = rsp_rights_ff;
      rsp_ok_in      = rsp_ok_ff;
      wr_en          = 1'b0;
      wr_addr        = scan_ff;
      wr_data        = '0;
      rd_addr        = scan_ff;
      req_ready      = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (last_slot) begin
               scan_in  = '0;
               state_in = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               act_in        = req_action;
               hdl_in        = req_handle_index;
               need_in       = req_rights_mask[RW-1:0];
               res_status_in = ST_OK;
               res_handle_in = '0;
               res_obj_in    = '0;
               res_rights_in = '0;
               res_ok_in     = 1'b0;
               state_in      = S_RESP;
               if (req_action == ACT_GRANT) begin
                  if (req_object_id == '0) begin
                     res_status_in = ST_BAD;
                  end else if (full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     work_obj_in    = req_object_id;
                     work_rights_in = req_rights_mask[RW-1:0];
                     scan_in        = '0;
                     state_in       = S_SCAN;
                  end
               end else if (req_action > ACT_CLOSE ||
                            req_idx_ext >= IDX_W'(TABLE_ENTRIES)) begin
                  res_status_in = ST_BAD;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            rd_addr  = hdl_addr;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
            if (!e_valid) begin
               res_status_in = ST_BAD;
            end else begin
               unique case (act_ff)
                  ACT_LOOKUP: begin
                     res_obj_in    = e_obj;
                     res_rights_in = e_rights;
                     res_ok_in     = ((e_rights & need_ff) == need_ff);
                  end
                  ACT_DUP: begin
                     if ((e_rights & dup_need) != dup_need) begin
                        res_status_in = ST_NODUP;
                     end else if (full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        work_obj_in    = e_obj;
                        work_rights_in = e_rights & need_ff;
                        scan_in        = '0;
                        state_in       = S_SCAN;
                     end
                  end
                  ACT_RESTRICT: begin
                     if ((need_ff & ~e_rights) != '0) begin
                        res_status_in = ST_ESCAL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = hdl_addr;
                        wr_data       = {1'b1, e_obj, need_ff};
                        res_obj_in    = e_obj;
                        res_rights_in = need_ff;
                     end
                  end
                  ACT_CLOSE: begin
                     wr_en   = 1'b1;
                     wr_addr = hdl_addr;
                     wr_data = {1'b0, OBJECT_W'(0), NO_RIGHTS[RW-1:0]};
                     cnt_in  = cnt_ff - 1'b1;
                  end
                  default: begin
                     res_status_in = ST_BAD;
                  end
               endcase
            end
         end
         S_SCAN: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (e_valid) begin
               scan_in  = scan_ff + 1'b1;
               state_in = S_SCAN;
            end else begin
               wr_en         = 1'b1;
               wr_data       = {1'b1, work_obj_ff, work_rights_ff};
               cnt_in        = cnt_ff + 1'b1;
               res_handle_in = scan_ext[HANDLE_W-1:0];
               res_obj_in    = work_obj_ff;
               res_rights_in = work_rights_ff;
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_handle_in = res_handle_ff;
               rsp_obj_in    = res_obj_ff;
               rsp_rights_in = RIGHTS_W'(res_rights_ff);
               rsp_ok_in     = res_ok_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         scan_ff      <= '0;
         cnt_ff       <= '0;
         dup_ff       <= DUP_MASK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         cnt_ff       <= cnt_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      hdl_ff         <= hdl_in;
      need_ff        <= need_in;
      work_obj_ff    <= work_obj_in;
      work_rights_ff <= work_rights_in;
      res_status_ff  <= res_status_in;
      res_handle_ff  <= res_handle_in;
      res_obj_ff     <= res_obj_in;
      res_rights_ff  <= res_rights_in;
      res_ok_ff      <= res_ok_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_obj_ff     <= rsp_obj_in;
      rsp_rights_ff  <= rsp_rights_in;
      rsp_ok_ff      <= rsp_ok_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_handle = rsp_handle_ff;
   assign rsp_result_object = rsp_obj_ff;
   assign rsp_result_rights = rsp_rights_ff;
   assign rsp_rights_ok     = rsp_ok_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("live count above table size");

   a_error_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
      (rsp_result_handle == '0 && rsp_result_object == '0 &&
       rsp_result_rights == '0 && !rsp_rights_ok))
      else $error("error response carries payload");

   a_place_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && !e_valid) |=>
      (cnt_ff == CNT_W'($past(cnt_ff) + 1'b1)))
      else $error("slot placed without count increment");

endmodule
